// ===== hdl/vwd_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex weld package
// Sizes, codes and shared types of the vertex weld and deduplication block.
// ----------------------------------------------------------------------------
`default_nettype none

package vwd_pkg;

	localparam int MAX_UNIQUE = 1024;
	localparam int MAX_VERTS  = 4096;

	localparam int COORD_W = 24;
	localparam int THR_W   = 24;
	localparam int TSQ_W   = 2 * THR_W;
	localparam int MAG_W   = COORD_W;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int IDX_W   = 32;

	localparam int UIDX_W = $clog2(MAX_UNIQUE);
	localparam int UCNT_W = $clog2(MAX_UNIQUE + 1);
	localparam int VIDX_W = $clog2(MAX_VERTS);
	localparam int VCNT_W = $clog2(MAX_VERTS + 1);

	typedef enum logic [1:0] {
		KIND_VERTEX = 2'd0,
		KIND_INDEX  = 2'd1,
		KIND_CLEAR  = 2'd2
	} vwd_kind_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_FULL = 2'd1,
		STATUS_PASS = 2'd2
	} vwd_status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} vwd_pos_t;

	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [UIDX_W-1:0] index;
		logic              busy;
	} vwd_match_t;

endpackage

`default_nettype wire

// ===== hdl/vwd_if.sv =====
// ----------------------------------------------------------------------------
// Vertex weld channels
// Request, response and threshold write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface vwd_req_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         kind;
	logic signed [vwd_pkg::COORD_W-1:0] pos_x;
	logic signed [vwd_pkg::COORD_W-1:0] pos_y;
	logic signed [vwd_pkg::COORD_W-1:0] pos_z;
	logic [vwd_pkg::IDX_W-1:0]          index_in;

	modport source (output valid, kind, pos_x, pos_y, pos_z, index_in, input ready);
	modport sink (input valid, kind, pos_x, pos_y, pos_z, index_in, output ready);
endinterface

interface vwd_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [vwd_pkg::IDX_W-1:0] unique_index;
	logic                      is_new;
	logic [1:0]                status;

	modport source (output valid, unique_index, is_new, status, input ready);
	modport sink (input valid, unique_index, is_new, status, output ready);
endinterface

interface vwd_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [vwd_pkg::THR_W-1:0] weld_threshold;

	modport source (output valid, weld_threshold, input ready);
	modport sink (input valid, weld_threshold, output ready);
endinterface

`default_nettype wire

// ===== hdl/vertex_weld_dedup_unit.sv =====
// ----------------------------------------------------------------------------
// Vertex weld and deduplication unit
// Welds vertex positions against a table of unique positions by distance and
// keeps a remap table from vertex order to unique index.
// ----------------------------------------------------------------------------
//
//  Channel | Role   | Payload
//  --------+--------+------------------------------------------------------
//  req     | sink   | kind, pos_x, pos_y, pos_z, index_in
//  rsp     | source | unique_index, is_new, status
//  cfg     | sink   | weld_threshold, always ready
//
//  A vertex request compares the query with each stored position in order,
//  reading the position memory sequentially, and stops at the first match.
//  Index requests in range read the remap table; clear, unused, refused vertex
//  and out-of-range index requests go straight to the response. A new request
//  waits until the last has gone to the response register. Reset empties both
//  tables at once, their contents never being cleared, and a request is taken while a response waits.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_weld_dedup_unit (
	input wire logic clk,
	input wire logic arst_n,
	vwd_req_if.sink   req,
	vwd_rsp_if.source rsp,
	vwd_cfg_if.sink   cfg
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_RWAIT,
		S_EMIT
	} state_t;

	state_t                     state_q;
	logic [vwd_pkg::THR_W-1:0]  thr_q;
	logic [vwd_pkg::TSQ_W-1:0]  tsq_q;
	logic [vwd_pkg::UCNT_W-1:0] ucount_q;
	logic [vwd_pkg::VCNT_W-1:0] vcount_q;
	logic [vwd_pkg::UCNT_W-1:0] scan_addr_q;
	logic                       found_q;
	logic [vwd_pkg::UIDX_W-1:0] hit_idx_q;
	vwd_pkg::vwd_pos_t          pos_q;
	logic [vwd_pkg::IDX_W-1:0]  res_index_q;
	logic                       res_new_q;
	logic [1:0]                 res_status_q;
	logic                       rsp_valid_q;
	logic [vwd_pkg::IDX_W-1:0]  rsp_index_q;
	logic                       rsp_new_q;
	logic [1:0]                 rsp_status_q;

	vwd_pkg::vwd_pos_t          stored;
	vwd_pkg::vwd_match_t        match;
	logic                       accept;
	logic                       issue;
	logic                       flush;
	logic                       idx_in_range;
	logic                       unique_full;
	logic                       verts_full;
	logic                       finish_we;
	logic                       append;
	logic [vwd_pkg::UIDX_W-1:0] finish_uidx;
	logic [vwd_pkg::UIDX_W-1:0] remap_rdata;
	logic                       rsp_free;

	assign accept       = (state_q == S_IDLE) && req.valid;
	assign req.ready    = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign idx_in_range = req.index_in < vwd_pkg::IDX_W'(vcount_q);
	assign unique_full  = ucount_q == vwd_pkg::UCNT_W'(vwd_pkg::MAX_UNIQUE);
	assign verts_full   = vcount_q == vwd_pkg::VCNT_W'(vwd_pkg::MAX_VERTS);
	assign flush        = (state_q == S_SCAN) && match.valid && match.hit;
	assign issue        = (state_q == S_SCAN) && (scan_addr_q < ucount_q) && !flush;
	assign finish_we    = (state_q == S_FINISH);
	assign append       = finish_we && !found_q && !unique_full;
	assign finish_uidx  = found_q ? hit_idx_q :
	                      (unique_full ? '0 : ucount_q[vwd_pkg::UIDX_W-1:0]);
	assign rsp_free     = !rsp_valid_q || rsp.ready;

	vwd_ram #(
		.WIDTH ($bits(vwd_pkg::vwd_pos_t)),
		.DEPTH (vwd_pkg::MAX_UNIQUE)
	) u_pos_ram (
		.clk   (clk),
		.we    (append),
		.waddr (ucount_q[vwd_pkg::UIDX_W-1:0]),
		.wdata (pos_q),
		.re    (issue),
		.raddr (scan_addr_q[vwd_pkg::UIDX_W-1:0]),
		.rdata (stored)
	);

	vwd_ram #(
		.WIDTH (vwd_pkg::UIDX_W),
		.DEPTH (vwd_pkg::MAX_VERTS)
	) u_remap_ram (
		.clk   (clk),
		.we    (finish_we),
		.waddr (vcount_q[vwd_pkg::VIDX_W-1:0]),
		.wdata (finish_uidx),
		.re    (accept),
		.raddr (req.index_in[vwd_pkg::VIDX_W-1:0]),
		.rdata (remap_rdata)
	);

	vwd_dist u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.flush       (flush),
		.issue       (issue),
		.issue_index (scan_addr_q[vwd_pkg::UIDX_W-1:0]),
		.stored      (stored),
		.query       (pos_q),
		.tsq         (tsq_q),
		.match       (match)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q.x <= req.pos_x;
			pos_q.y <= req.pos_y;
			pos_q.z <= req.pos_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			thr_q        <= '0;
			tsq_q        <= '0;
			ucount_q     <= '0;
			vcount_q     <= '0;
			scan_addr_q  <= '0;
			found_q      <= 1'b0;
			hit_idx_q    <= '0;
			res_index_q  <= '0;
			res_new_q    <= 1'b0;
			res_status_q <= vwd_pkg::STATUS_OK;
			rsp_valid_q  <= 1'b0;
			rsp_index_q  <= '0;
			rsp_new_q    <= 1'b0;
			rsp_status_q <= vwd_pkg::STATUS_OK;
		end else begin
			if (cfg.valid) begin
				thr_q <= cfg.weld_threshold;
			end
			tsq_q <= vwd_pkg::TSQ_W'(thr_q) * vwd_pkg::TSQ_W'(thr_q);

			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						res_index_q  <= '0;
						res_new_q    <= 1'b0;
						res_status_q <= vwd_pkg::STATUS_OK;
						found_q      <= 1'b0;
						scan_addr_q  <= '0;
						unique case (req.kind)
							vwd_pkg::KIND_VERTEX: begin
								if (verts_full) begin
									res_status_q <= vwd_pkg::STATUS_FULL;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_SCAN;
								end
							end
							vwd_pkg::KIND_INDEX: begin
								if (idx_in_range) begin
									state_q <= S_RWAIT;
								end else begin
									res_index_q  <= req.index_in;
									res_status_q <= vwd_pkg::STATUS_PASS;
									state_q      <= S_EMIT;
								end
							end
							vwd_pkg::KIND_CLEAR: begin
								ucount_q <= '0;
								vcount_q <= '0;
								state_q  <= S_EMIT;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_addr_q <= scan_addr_q + 1'b1;
					end
					if (flush) begin
						found_q   <= 1'b1;
						hit_idx_q <= match.index;
						state_q   <= S_FINISH;
					end else if (!issue && !match.busy) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					res_index_q <= vwd_pkg::IDX_W'(finish_uidx);
					res_new_q   <= append;
					if (!found_q && unique_full) begin
						res_status_q <= vwd_pkg::STATUS_FULL;
					end
					if (append) begin
						ucount_q <= ucount_q + 1'b1;
					end
					vcount_q <= vcount_q + 1'b1;
					state_q  <= S_EMIT;
				end
				S_RWAIT: begin
					res_index_q <= vwd_pkg::IDX_W'(remap_rdata);
					state_q     <= S_EMIT;
				end
				S_EMIT: begin
					if (rsp_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_index_q  <= res_index_q;
						rsp_new_q    <= res_new_q;
						rsp_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.unique_index = rsp_index_q;
	assign rsp.is_new       = rsp_new_q;
	assign rsp.status       = rsp_status_q;

endmodule

`default_nettype wire

// ===== hdl/vwd_ram.sv =====
// ----------------------------------------------------------------------------
// Vertex weld RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/vwd_dist.sv =====
// ----------------------------------------------------------------------------
// Vertex weld distance pipeline
// Compares one stored position a cycle against the query by squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

module vwd_dist (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       flush,
	input  wire logic                       issue,
	input  wire logic [vwd_pkg::UIDX_W-1:0] issue_index,
	input  wire vwd_pkg::vwd_pos_t          stored,
	input  wire vwd_pkg::vwd_pos_t          query,
	input  wire logic [vwd_pkg::TSQ_W-1:0]  tsq,
	output      vwd_pkg::vwd_match_t        match
);

	localparam int SUM_W = vwd_pkg::SQ_W + 2;

	function automatic logic [vwd_pkg::MAG_W-1:0] abs_diff(
		input logic signed [vwd_pkg::COORD_W-1:0] a,
		input logic signed [vwd_pkg::COORD_W-1:0] b
	);
		logic signed [vwd_pkg::COORD_W:0] d;
		logic signed [vwd_pkg::COORD_W:0] m;
		d = $signed({a[vwd_pkg::COORD_W-1], a}) - $signed({b[vwd_pkg::COORD_W-1], b});
		m = d[vwd_pkg::COORD_W] ? -d : d;
		return m[vwd_pkg::MAG_W-1:0];
	endfunction

	logic                       vld_s1, vld_s2, vld_s3, vld_s4;
	logic [vwd_pkg::UIDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [vwd_pkg::MAG_W-1:0]  ax_s2, ay_s2, az_s2;
	logic [vwd_pkg::SQ_W-1:0]   sx_s3, sy_s3, sz_s3;
	logic                       hit_s4;
	logic [SUM_W-1:0]           dsq;

	assign dsq = SUM_W'(sx_s3) + SUM_W'(sy_s3) + SUM_W'(sz_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= issue && !flush;
			vld_s2 <= vld_s1 && !flush;
			vld_s3 <= vld_s2 && !flush;
			vld_s4 <= vld_s3 && !flush;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_index;
		idx_s2 <= idx_s1;
		ax_s2  <= abs_diff(query.x, stored.x);
		ay_s2  <= abs_diff(query.y, stored.y);
		az_s2  <= abs_diff(query.z, stored.z);
		idx_s3 <= idx_s2;
		sx_s3  <= vwd_pkg::SQ_W'(ax_s2) * vwd_pkg::SQ_W'(ax_s2);
		sy_s3  <= vwd_pkg::SQ_W'(ay_s2) * vwd_pkg::SQ_W'(ay_s2);
		sz_s3  <= vwd_pkg::SQ_W'(az_s2) * vwd_pkg::SQ_W'(az_s2);
		idx_s4 <= idx_s3;
		hit_s4 <= dsq < SUM_W'(tsq);
	end

	assign match.valid = vld_s4;
	assign match.hit   = hit_s4;
	assign match.index = idx_s4;
	assign match.busy  = vld_s1 || vld_s2 || vld_s3 || vld_s4;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Vertex weld and deduplication unit testbench
// Drives vertex, index, clear and spare requests into the unit and predicts
// every response with a local model of the unique position and remap tables.
// A short directed sequence covers extreme coordinates, the strict threshold
// comparison, zero and widest weld distances and all request kinds.
// Randomised mesh batches follow, each with its own weld distance, mostly
// clustered vertices with index lookups mixed in. Both handshakes idle at
// random, and the response side holds off at length.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 550;
	localparam int SETTLE_CYCLES = vwd_pkg::MAX_UNIQUE + 16;
	localparam longint CYCLE_LIMIT = 4_000_000;
	localparam logic [vwd_pkg::THR_W-1:0] THR_MAX = '1;
	localparam int HUB_MAX = 8;
	localparam int HUB_W = $clog2(HUB_MAX);

	typedef struct {
		logic [1:0]                         kind;
		logic signed [vwd_pkg::COORD_W-1:0] pos_x;
		logic signed [vwd_pkg::COORD_W-1:0] pos_y;
		logic signed [vwd_pkg::COORD_W-1:0] pos_z;
		logic [vwd_pkg::IDX_W-1:0]          index_in;
	} weld_req_t;

	typedef struct {
		logic [vwd_pkg::IDX_W-1:0] unique_index;
		logic                      is_new;
		vwd_pkg::vwd_status_t      status;
	} weld_rsp_t;

	logic clk;
	logic arst_n;

	vwd_req_if req_ch ();
	vwd_rsp_if rsp_ch ();
	vwd_cfg_if cfg_ch ();

	vertex_weld_dedup_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	weld_req_t weld_requests[$];
	weld_rsp_t expected_welds[$];
	weld_req_t offered;
	logic      req_busy = 1'b0;
	logic      steady = 1'b0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        hold_left = 0;
	int        holds_asked = 0;
	int        holds_done = 0;
	int        errors = 0;
	longint    cycles = 0;

	logic signed [vwd_pkg::COORD_W-1:0] kept_x [vwd_pkg::MAX_UNIQUE];
	logic signed [vwd_pkg::COORD_W-1:0] kept_y [vwd_pkg::MAX_UNIQUE];
	logic signed [vwd_pkg::COORD_W-1:0] kept_z [vwd_pkg::MAX_UNIQUE];
	logic [vwd_pkg::UIDX_W-1:0]         remap_of [vwd_pkg::MAX_VERTS];
	int unsigned                        kept_count = 0;
	int unsigned                        vertex_total = 0;
	logic [vwd_pkg::THR_W-1:0]          threshold_now = '0;

	function automatic weld_rsp_t weld_predict(input weld_req_t r);
		weld_rsp_t         res;
		longint unsigned   tsq;
		longint unsigned   dsq;
		longint            dx;
		longint            dy;
		longint            dz;
		int unsigned       j;
		bit                hit;
		res = '{unique_index: '0, is_new: 1'b0, status: vwd_pkg::STATUS_OK};
		case (r.kind)
			vwd_pkg::KIND_VERTEX: begin
				if (vertex_total >= vwd_pkg::MAX_VERTS) begin
					res.status = vwd_pkg::STATUS_FULL;
				end else begin
					tsq = longint'(threshold_now) * longint'(threshold_now);
					hit = 1'b0;
					j = 0;
					while (!hit && j < kept_count) begin
						dx = longint'(r.pos_x) - longint'(kept_x[j[vwd_pkg::UIDX_W-1:0]]);
						dy = longint'(r.pos_y) - longint'(kept_y[j[vwd_pkg::UIDX_W-1:0]]);
						dz = longint'(r.pos_z) - longint'(kept_z[j[vwd_pkg::UIDX_W-1:0]]);
						dsq = dx * dx + dy * dy + dz * dz;
						if (dsq < tsq) begin
							hit = 1'b1;
						end else begin
							j++;
						end
					end
					if (hit) begin
						res.unique_index = j;
					end else if (kept_count < vwd_pkg::MAX_UNIQUE) begin
						kept_x[kept_count[vwd_pkg::UIDX_W-1:0]] = r.pos_x;
						kept_y[kept_count[vwd_pkg::UIDX_W-1:0]] = r.pos_y;
						kept_z[kept_count[vwd_pkg::UIDX_W-1:0]] = r.pos_z;
						res.unique_index = kept_count;
						res.is_new = 1'b1;
						kept_count++;
					end else begin
						res.status = vwd_pkg::STATUS_FULL;
					end
					remap_of[vertex_total[vwd_pkg::VIDX_W-1:0]] =
						res.unique_index[vwd_pkg::UIDX_W-1:0];
					vertex_total++;
				end
			end
			vwd_pkg::KIND_INDEX: begin
				if (r.index_in < vertex_total) begin
					res.unique_index =
						vwd_pkg::IDX_W'(remap_of[r.index_in[vwd_pkg::VIDX_W-1:0]]);
				end else begin
					res.unique_index = r.index_in;
					res.status = vwd_pkg::STATUS_PASS;
				end
			end
			vwd_pkg::KIND_CLEAR: begin
				kept_count = 0;
				vertex_total = 0;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic weld_req_t vertex_req(input logic signed [vwd_pkg::COORD_W-1:0] x,
			input logic signed [vwd_pkg::COORD_W-1:0] y,
			input logic signed [vwd_pkg::COORD_W-1:0] z);
		weld_req_t r;
		r.kind = vwd_pkg::KIND_VERTEX;
		r.pos_x = x;
		r.pos_y = y;
		r.pos_z = z;
		r.index_in = $urandom;
		return r;
	endfunction

	function automatic weld_req_t index_req(input logic [vwd_pkg::IDX_W-1:0] i);
		weld_req_t r;
		r.kind = vwd_pkg::KIND_INDEX;
		r.pos_x = vwd_pkg::COORD_W'($urandom);
		r.pos_y = vwd_pkg::COORD_W'($urandom);
		r.pos_z = vwd_pkg::COORD_W'($urandom);
		r.index_in = i;
		return r;
	endfunction

	function automatic weld_req_t op_req(input logic [1:0] k);
		weld_req_t r;
		r = index_req($urandom);
		r.kind = k;
		return r;
	endfunction

	function automatic weld_req_t scatter_req();
		return vertex_req(vwd_pkg::COORD_W'($urandom), vwd_pkg::COORD_W'($urandom),
			vwd_pkg::COORD_W'($urandom));
	endfunction

	task automatic queue_request(input weld_req_t r);
		weld_requests = {weld_requests, r};
	endtask

	task automatic settle();
		while (weld_requests.size() != 0 || req_busy || expected_welds.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_threshold(input logic [vwd_pkg::THR_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.weld_threshold <= value;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		cfg_ch.valid <= 1'b0;
		threshold_now = value;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			gap_left <= 0;
			req_busy = 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_welds = {expected_welds, weld_predict(offered)};
				req_busy = 1'b0;
			end
			if (!req_busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_ch.valid <= 1'b0;
				end else if (weld_requests.size() > 0) begin
					offered = weld_requests.pop_front();
					req_busy = 1'b1;
					req_ch.valid <= 1'b1;
					req_ch.kind <= offered.kind;
					req_ch.pos_x <= offered.pos_x;
					req_ch.pos_y <= offered.pos_y;
					req_ch.pos_z <= offered.pos_z;
					req_ch.index_in <= offered.index_in;
					gap_left <= steady ? 0 : $urandom_range(0, 9);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			holds_done <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done != holds_asked) begin
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin : response_check
		weld_rsp_t want;
		int        wait_n;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			wait_n = stall_left;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_welds.size() == 0) begin
					errors++;
					$display("%0t: response without a request: index %0d new %0d status %0d",
						$time, rsp_ch.unique_index, rsp_ch.is_new, rsp_ch.status);
				end else begin
					want = expected_welds.pop_front();
					if (rsp_ch.unique_index !== want.unique_index ||
							rsp_ch.is_new !== want.is_new ||
							rsp_ch.status !== want.status) begin
						errors++;
						$display("%0t: expected index %0d new %0d status %0d, got %0d %0d %0d",
							$time, want.unique_index, want.is_new, want.status,
							rsp_ch.unique_index, rsp_ch.is_new, rsp_ch.status);
					end
				end
				wait_n = steady ? 0 : $urandom_range(0, 9);
			end else if (!rsp_ch.ready && wait_n > 0) begin
				wait_n--;
			end
			stall_left <= wait_n;
			rsp_ch.ready <= (wait_n == 0) && (hold_left == 0);
		end
	end

	initial begin : stimulus
		logic signed [vwd_pkg::COORD_W-1:0] hub_x [HUB_MAX];
		logic signed [vwd_pkg::COORD_W-1:0] hub_y [HUB_MAX];
		logic signed [vwd_pkg::COORD_W-1:0] hub_z [HUB_MAX];
		logic [vwd_pkg::THR_W-1:0]          thr;
		int                                 hubs;
		int                                 n_vert;
		int                                 made;
		int                                 pick;
		int                                 span;
		int                                 h;
		int                                 placed;
		bit                                 first_batch;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = vwd_pkg::KIND_VERTEX;
		req_ch.pos_x = '0;
		req_ch.pos_y = '0;
		req_ch.pos_z = '0;
		req_ch.index_in = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.weld_threshold = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// A distance of exactly the threshold must not weld; one step less must.
		write_threshold(24'h001000);
		queue_request(vertex_req(24'sh000000, 24'sh000000, 24'sh000000));
		queue_request(vertex_req(24'sh001000, 24'sh000000, 24'sh000000));
		queue_request(vertex_req(24'sh000FFF, 24'sh000000, 24'sh000000));
		queue_request(vertex_req(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
		queue_request(vertex_req(24'sh800000, 24'sh800000, 24'sh800000));
		queue_request(vertex_req(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF));
		queue_request(vertex_req(24'sh7FFFFE, 24'sh7FFFFF, 24'sh7FFFFF));
		queue_request(index_req(32'd0));
		queue_request(index_req(32'd2));
		queue_request(index_req(32'd6));
		queue_request(index_req(32'd7));
		queue_request(index_req(32'hFFFFFFFF));
		queue_request(op_req(KIND_SPARE));
		queue_request(op_req(vwd_pkg::KIND_CLEAR));
		queue_request(index_req(32'd0));
		queue_request(vertex_req(24'sh000000, 24'sh000000, 24'sh000000));
		settle();

		// With a zero distance even identical positions stay apart.
		write_threshold('0);
		queue_request(op_req(vwd_pkg::KIND_CLEAR));
		queue_request(vertex_req(24'sh000005, 24'sh000005, 24'sh000005));
		queue_request(vertex_req(24'sh000005, 24'sh000005, 24'sh000005));
		queue_request(index_req(32'd1));
		settle();

		write_threshold(THR_MAX);
		queue_request(op_req(vwd_pkg::KIND_CLEAR));
		queue_request(vertex_req(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
		queue_request(vertex_req(24'sh800000, 24'sh800000, 24'sh800000));
		queue_request(vertex_req(24'sh000000, 24'sh000000, 24'sh000000));
		settle();

		placed = 0;
		first_batch = 1'b1;
		while (placed < RANDOM_ITEMS) begin
			case ($urandom_range(0, 4))
				0: thr = '0;
				1: thr = vwd_pkg::THR_W'($urandom_range(1, 24'h001000));
				2: thr = vwd_pkg::THR_W'($urandom_range(24'h001000, 24'h080000));
				3: thr = THR_MAX;
				default: thr = vwd_pkg::THR_W'($urandom);
			endcase
			settle();
			write_threshold(thr);
			steady = ($urandom_range(0, 3) == 0);
			hubs = $urandom_range(1, HUB_MAX);
			for (int k = 0; k < hubs; k++) begin
				hub_x[k[HUB_W-1:0]] = vwd_pkg::COORD_W'($urandom);
				hub_y[k[HUB_W-1:0]] = vwd_pkg::COORD_W'($urandom);
				hub_z[k[HUB_W-1:0]] = vwd_pkg::COORD_W'($urandom);
			end
			span = int'(thr) * 2 + 1;
			queue_request(op_req(vwd_pkg::KIND_CLEAR));
			made = 0;
			placed++;
			n_vert = $urandom_range(4, 40);
			repeat (n_vert) begin
				pick = $urandom_range(0, 19);
				h = $urandom_range(0, hubs - 1);
				if (pick < 12) begin
					queue_request(vertex_req(
						vwd_pkg::COORD_W'(int'(hub_x[h[HUB_W-1:0]]) +
							int'($urandom_range(0, 2 * span)) - span),
						vwd_pkg::COORD_W'(int'(hub_y[h[HUB_W-1:0]]) +
							int'($urandom_range(0, 2 * span)) - span),
						vwd_pkg::COORD_W'(int'(hub_z[h[HUB_W-1:0]]) +
							int'($urandom_range(0, 2 * span)) - span)));
				end else if (pick < 16) begin
					queue_request(vertex_req(hub_x[h[HUB_W-1:0]], hub_y[h[HUB_W-1:0]],
						hub_z[h[HUB_W-1:0]]));
				end else begin
					queue_request(scatter_req());
				end
				made++;
				placed++;
				if ($urandom_range(0, 2) == 0) begin
					pick = $urandom_range(0, 19);
					if (pick < 14) begin
						queue_request(index_req($urandom_range(0, made - 1)));
					end else if (pick < 17) begin
						queue_request(index_req(made + $urandom_range(0, 2)));
					end else if (pick < 19) begin
						queue_request(index_req($urandom));
					end else begin
						queue_request(op_req(KIND_SPARE));
					end
					placed++;
				end
				if ($urandom_range(0, 59) == 0) begin
					queue_request(op_req(vwd_pkg::KIND_CLEAR));
					made = 0;
					placed++;
				end
			end
			if (first_batch) begin
				holds_asked++;
				first_batch = 1'b0;
			end
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== vertex_weld_dedup_unit.f =====
hdl/vwd_pkg.sv
hdl/vwd_if.sv
hdl/vwd_ram.sv
hdl/vwd_dist.sv
hdl/vertex_weld_dedup_unit.sv
tb/sv/testbench.sv
